[hw/rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also runs through reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/bms_pkg.sv]
`default_nettype none

package bms_pkg;

    localparam int STRENGTH_W = 31;
    localparam int TAG_W      = 32;
    localparam int CAP_W      = 6;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LIST   = 1'b1;

    localparam logic [1:0] CAUSE_BEATEN  = 2'd0;
    localparam logic [1:0] CAUSE_DROPPED = 2'd1;
    localparam logic [1:0] CAUSE_LISTED  = 2'd2;

    typedef struct packed {
        logic                  action;
        logic [STRENGTH_W-1:0] strength;
        logic [TAG_W-1:0]      tag;
    } in_item_t;

    typedef struct packed {
        logic [TAG_W-1:0] out_tag;
        logic [1:0]       cause;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic [STRENGTH_W-1:0] strength;
        logic [TAG_W-1:0]      tag;
    } entry_t;

    typedef struct packed {
        logic      load;
        out_item_t item;
    } result_load_t;

endpackage

`default_nettype wire

[hw/rtl/bms_ram.sv]
`default_nettype none

module bms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hw/rtl/bms_ctrl.sv]
`default_nettype none

module bms_ctrl import bms_pkg::*; #(
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire in_item_t     item,
    output logic              idle,
    input  wire logic [CAP_W-1:0] capacity,
    input  wire logic         out_free,
    output result_load_t      emit_out,
    output logic              ram_we,
    output logic [AW-1:0]     ram_waddr,
    output entry_t            ram_wdata,
    output logic [AW-1:0]     ram_raddr,
    input  wire entry_t       ram_rdata
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_EV    = 3'd2;
    localparam logic [2:0] S_CAP   = 3'd3;
    localparam logic [2:0] S_DRD   = 3'd4;
    localparam logic [2:0] S_DEV   = 3'd5;
    localparam logic [2:0] S_PUSH  = 3'd6;
    localparam logic [2:0] S_FLUSH = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         base_reg, base_next;
    logic [AW-1:0]         cursor_reg, cursor_next;
    logic                  pend_valid_reg, pend_valid_next;
    out_item_t             pend_reg, pend_next;
    logic                  act_reg, act_next;
    logic [STRENGTH_W-1:0] str_reg, str_next;
    logic [TAG_W-1:0]      tag_reg, tag_next;

    logic                  want_emit;
    logic                  can_emit;
    out_item_t             new_item;
    logic [CMPW-1:0]       count_ext;
    logic [CMPW-1:0]       cap_ext;
    logic [CMPW-1:0]       eff_cap;
    logic                  need_drop;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    // capacity of zero acts as one, above DEPTH acts as DEPTH
    always_comb begin
        count_ext = CMPW'(count_reg);
        cap_ext   = CMPW'(capacity);
        if (cap_ext == '0) begin
            eff_cap = CMPW'(1);
        end else if (cap_ext > CMPW'(DEPTH)) begin
            eff_cap = CMPW'(DEPTH);
        end else begin
            eff_cap = cap_ext;
        end
        need_drop = (count_ext >= eff_cap) && (count_reg != '0);
    end

    assign idle      = (state_reg == S_IDLE);
    assign ram_raddr = wrap_add(base_reg, cursor_reg);
    assign can_emit  = !pend_valid_reg || out_free;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        base_next       = base_reg;
        cursor_next     = cursor_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        act_next        = act_reg;
        str_next        = str_reg;
        tag_next        = tag_reg;
        want_emit       = 1'b0;
        new_item        = '{out_tag: ram_rdata.tag, cause: CAUSE_LISTED, last: 1'b0};
        emit_out        = '{load: 1'b0, item: pend_reg};
        ram_we          = 1'b0;
        ram_waddr       = wrap_add(base_reg, count_reg[AW-1:0]);
        ram_wdata       = '{strength: str_reg, tag: tag_reg};

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    act_next    = item.action;
                    str_next    = item.strength;
                    tag_next    = item.tag;
                    cursor_next = AW'(count_reg - 1'b1);
                    if (count_reg == '0) begin
                        state_next = (item.action == ACT_LIST) ? S_FLUSH : S_CAP;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                state_next = S_EV;
            end
            S_EV: begin
                if (act_reg == ACT_LIST) begin
                    want_emit = 1'b1;
                    if (can_emit) begin
                        if (cursor_reg == '0) begin
                            state_next = S_FLUSH;
                        end else begin
                            cursor_next = cursor_reg - 1'b1;
                            state_next  = S_RD;
                        end
                    end
                end else if (ram_rdata.strength < str_reg) begin
                    want_emit      = 1'b1;
                    new_item.cause = CAUSE_BEATEN;
                    if (can_emit) begin
                        count_next = count_reg - 1'b1;
                        if (cursor_reg == '0) begin
                            state_next = S_CAP;
                        end else begin
                            cursor_next = cursor_reg - 1'b1;
                            state_next  = S_RD;
                        end
                    end
                end else begin
                    state_next = S_CAP;
                end
            end
            S_CAP: begin
                cursor_next = '0;
                state_next  = need_drop ? S_DRD : S_PUSH;
            end
            S_DRD: begin
                state_next = S_DEV;
            end
            S_DEV: begin
                want_emit      = 1'b1;
                new_item.cause = CAUSE_DROPPED;
                if (can_emit) begin
                    base_next  = wrap_add(base_reg, AW'(1));
                    count_next = count_reg - 1'b1;
                    state_next = S_PUSH;
                end
            end
            S_PUSH: begin
                ram_we     = 1'b1;
                count_next = count_reg + 1'b1;
                state_next = S_FLUSH;
            end
            S_FLUSH: begin
                // release the held word as the item's final result
                if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_free) begin
                    emit_out.load      = 1'b1;
                    emit_out.item.last = 1'b1;
                    pend_valid_next    = 1'b0;
                    state_next         = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // hold each new word one step so its last flag is known when it leaves
        if (want_emit && can_emit) begin
            if (pend_valid_reg) begin
                emit_out.load = 1'b1;
            end
            pend_next       = new_item;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            base_reg       <= '0;
            cursor_reg     <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            base_reg       <= base_next;
            cursor_reg     <= cursor_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        act_reg  <= act_next;
        str_reg  <= str_next;
        tag_reg  <= tag_next;
    end

endmodule

`default_nettype wire

[hw/rtl/bounded_monotonic_stack_unit.sv]
// Sequence: an insert reads and compares each entry from the top (each popped one and the one
// that stops the pops), checks capacity, reads and drops the oldest entry when full, pushes and
// releases its final word; a listing emits each entry from the top, then its last word. A word
// waiting on m_ready stalls the sequence. One item at a time, the next accepted only when idle
// again, set by the registered read of the single entry memory feeding one compare unit.
// Reset (aresetn low, synchronous): stack emptied, capacity 32, no word pending, memory kept.
`default_nettype none

module bounded_monotonic_stack_unit import bms_pkg::*; #(
    parameter int DEPTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire in_item_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output out_item_t             m_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data
);

    localparam int AW = $clog2(DEPTH);

    logic [CAP_W-1:0] capacity_reg;
    logic             m_valid_reg;
    out_item_t        m_data_reg;
    logic             idle;
    logic             out_free;
    result_load_t     emit;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    entry_t           ram_wdata;
    entry_t           ram_rdata;

    assign cfg_ready = 1'b1;
    assign s_ready   = idle;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                capacity_reg <= cfg_data;
            end
            if (emit.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.load) begin
            m_data_reg <= emit.item;
        end
    end

    bms_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_valid && s_ready),
        .item      (s_data),
        .idle      (idle),
        .capacity  (capacity_reg),
        .out_free  (out_free),
        .emit_out  (emit),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    bms_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

endmodule

`default_nettype wire

[hw/rtl/bms_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module bms_checker import bms_pkg::*; (
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_valid,
    input wire logic             s_ready,
    input wire in_item_t         s_data,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire out_item_t        m_data,
    input wire logic             cfg_valid,
    input wire logic             cfg_ready,
    input wire logic [CAP_W-1:0] cfg_data
);

    // a stalled result word must hold
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result word changed while stalled")

    `ASSERT_CLK(a_cause_code, aclk, aresetn, m_valid |-> (m_data.cause == CAUSE_BEATEN || m_data.cause == CAUSE_DROPPED || m_data.cause == CAUSE_LISTED), "undefined cause code")

    // leaving reset the unit is idle and has nothing to send
    `ASSERT_CLK_ALWAYS(a_reset_idle, aclk, !aresetn |=> s_ready && !m_valid, "not idle after reset")

    // an accepted item always occupies the sequencer, so no item is taken in the cycle after
    `ASSERT_CLK(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready, "input taken back to back")

endmodule

bind bounded_monotonic_stack_unit bms_checker u_bms_checker (.*);

`default_nettype wire
